FILE: rtl/core/cdq_pkg.sv
// Types and codes shared by the deque modules.
`timescale 1ns / 1ps
package cdq_pkg;

  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_BACK  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_BACK   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  localparam int unsigned WORD_W = 32;

  typedef struct packed {
    logic    we;
    logic    pop_ok;
    status_t status;
  } op_ctl_t;

endpackage

FILE: rtl/core/circular_deque_unit.sv
// Top level of the ring-buffer double-ended queue.
`timescale 1ns / 1ps
// Takes one request in every clock cycle: busy stays low, and a request is
// taken at any edge where start is high. Its result appears on done and the
// result ports in the next cycle, the delay of the ring memory's
// registered read, and must be taken in that cycle. A refused push or pop
// leaves the contents unchanged. Storage is not cleared at reset; only
// written entries are ever returned.
module circular_deque_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  kind,
  input  logic [31:0]                 push_value,
  output logic                        done,
  output logic [31:0]                 pop_value,
  output logic [1:0]                  status,
  output logic [$clog2(DEPTH+1)-1:0]  count_after,
  output logic                        is_empty
);
  import cdq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic              we;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [WORD_W-1:0] rd_data;

  assign busy = 1'b0;

  cdq_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .CW   (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .kind       (kind),
    .rd_data    (rd_data),
    .we         (we),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .done       (done),
    .pop_value  (pop_value),
    .status     (status),
    .count_after(count_after),
    .is_empty   (is_empty)
  );

  cdq_ring_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk    (clk),
    .we     (we),
    .wr_addr(wr_addr),
    .wr_data(push_value),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule

FILE: rtl/core/cdq_ring_mem.sv
// Ring storage: one write port and one registered read port.
`timescale 1ns / 1ps
module cdq_ring_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            wr_addr,
  input  logic [cdq_pkg::WORD_W-1:0] wr_data,
  input  logic [AW-1:0]            rd_addr,
  output logic [cdq_pkg::WORD_W-1:0] rd_data
);
  import cdq_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/cdq_ctrl.sv
// Head and count registers, slot addressing and result staging.
`timescale 1ns / 1ps
module cdq_ctrl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned CW    = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [1:0]                 kind,
  input  logic [cdq_pkg::WORD_W-1:0] rd_data,
  output logic                       we,
  output logic [AW-1:0]              wr_addr,
  output logic [AW-1:0]              rd_addr,
  output logic                       done,
  output logic [cdq_pkg::WORD_W-1:0] pop_value,
  output logic [1:0]                 status,
  output logic [CW-1:0]              count_after,
  output logic                       is_empty
);
  import cdq_pkg::*;

  localparam int unsigned SW = AW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  op_ctl_t       ctl;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic          out_valid, out_pop_ok, out_empty;
  status_t       out_status;
  logic [CW-1:0] out_count;

  logic [AW-1:0] front_prev, front_succ, back_slot, back_last;
  logic [SW-1:0] sum_b, sum_l;
  logic          full, empty;
  kind_t         op;

  always_comb begin
    op         = kind_t'(kind);
    full       = (count == DEPTH_C);
    empty      = (count == '0);
    front_prev = (head == '0) ? LAST_A : head - AW'(1);
    front_succ = (head == LAST_A) ? '0 : head + AW'(1);
    sum_b      = SW'(head) + SW'(count);
    sum_l      = sum_b - SW'(1);
    back_slot  = (sum_b >= DEPTH_S) ? AW'(sum_b - DEPTH_S) : AW'(sum_b);
    back_last  = (sum_l >= DEPTH_S) ? AW'(sum_l - DEPTH_S) : AW'(sum_l);

    head_next   = head;
    count_next  = count;
    ctl.we      = 1'b0;
    ctl.pop_ok  = 1'b0;
    ctl.status  = ST_DONE;
    wr_addr     = back_slot;
    rd_addr     = head;

    case (op)
      KIND_PUSH_FRONT: begin
        wr_addr = front_prev;
        if (full) begin
          ctl.status = ST_FULL;
        end else begin
          ctl.we     = start;
          head_next  = front_prev;
          count_next = count + CW'(1);
        end
      end
      KIND_PUSH_BACK: begin
        if (full) begin
          ctl.status = ST_FULL;
        end else begin
          ctl.we     = start;
          count_next = count + CW'(1);
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          ctl.status = ST_EMPTY;
        end else begin
          ctl.pop_ok = 1'b1;
          head_next  = front_succ;
          count_next = count - CW'(1);
        end
      end
      KIND_POP_BACK: begin
        rd_addr = back_last;
        if (empty) begin
          ctl.status = ST_EMPTY;
        end else begin
          ctl.pop_ok = 1'b1;
          count_next = count - CW'(1);
        end
      end
      default: begin
        ctl.status = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= start;
      if (start) begin
        head  <= head_next;
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      out_pop_ok <= ctl.pop_ok;
      out_status <= ctl.status;
      out_count  <= count_next;
      out_empty  <= (count_next == '0);
    end
  end

  assign we          = ctl.we;
  assign done        = out_valid;
  assign pop_value   = out_pop_ok ? rd_data : '0;
  assign status      = out_status;
  assign count_after = out_count;
  assign is_empty    = out_empty;

endmodule

FILE: verif/cdq_checker.sv
// Checker for the deque unit: predicts each request's result and compares it with the block.
`timescale 1ns / 1ps
module cdq_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [1:0]                  kind,
  input  logic [31:0]                 push_value,
  input  logic                        done,
  input  logic [31:0]                 pop_value,
  input  logic [1:0]                  status,
  input  logic [$clog2(DEPTH+1)-1:0]  count_after,
  input  logic                        is_empty,
  output int                          fail_count,
  output int                          results_seen,
  output int                          pending,
  output int                          full_refusals,
  output int                          empty_refusals
);
  import cdq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH+1);

  typedef struct {
    logic [31:0]      pop_value;
    status_t          status;
    logic [CNT_W-1:0] count_after;
    logic             is_empty;
  } deque_result_t;

  logic [31:0]   ring [DEPTH];
  int unsigned   head;
  int unsigned   count;
  deque_result_t result_q [$];

  function automatic deque_result_t apply_request(kind_t k, logic [31:0] word);
    deque_result_t r;
    int unsigned   slot;
    r.pop_value = '0;
    r.status    = ST_DONE;
    if (k == KIND_PUSH_FRONT || k == KIND_PUSH_BACK) begin
      if (count >= DEPTH) begin
        r.status = ST_FULL;
      end else if (k == KIND_PUSH_FRONT) begin
        slot       = (head + DEPTH - 1) % DEPTH;
        ring[slot] = word;
        head       = slot;
        count++;
      end else begin
        slot       = (head + count) % DEPTH;
        ring[slot] = word;
        count++;
      end
    end else begin
      if (count == 0) begin
        r.status = ST_EMPTY;
      end else if (k == KIND_POP_FRONT) begin
        r.pop_value = ring[head];
        head        = (head + 1) % DEPTH;
        count--;
      end else begin
        slot        = (head + count - 1) % DEPTH;
        r.pop_value = ring[slot];
        count--;
      end
    end
    r.count_after = CNT_W'(count);
    r.is_empty    = (count == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    deque_result_t exp_r;
    int            errs;
    if (rst) begin
      head  = 0;
      count = 0;
      result_q.delete();
      fail_count     <= 0;
      results_seen   <= 0;
      full_refusals  <= 0;
      empty_refusals <= 0;
    end else begin
      if (start && !busy) begin
        exp_r = apply_request(kind_t'(kind), push_value);
        if (exp_r.status == ST_FULL) full_refusals <= full_refusals + 1;
        if (exp_r.status == ST_EMPTY) empty_refusals <= empty_refusals + 1;
        result_q.push_back(exp_r);
      end
      if (done) begin
        results_seen <= results_seen + 1;
        if (result_q.size() == 0) begin
          $error("result with no request outstanding: pop_value %h status %0d", pop_value,
                 status);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = result_q.pop_front();
          errs  = 0;
          if (pop_value !== exp_r.pop_value) begin
            $error("pop_value expected %h actual %h", exp_r.pop_value, pop_value);
            errs++;
          end
          if (status !== exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, status);
            errs++;
          end
          if (count_after !== exp_r.count_after) begin
            $error("count_after expected %0d actual %0d", exp_r.count_after, count_after);
            errs++;
          end
          if (is_empty !== exp_r.is_empty) begin
            $error("is_empty expected %0d actual %0d", exp_r.is_empty, is_empty);
            errs++;
          end
          if (errs != 0) fail_count <= fail_count + 1;
        end
      end
    end
    pending <= result_q.size();
  end

endmodule

FILE: verif/tb_circular_deque_unit.sv
// Testbench top for the deque unit: reset, request stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb_circular_deque_unit;
  import cdq_pkg::*;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned CNT_W      = $clog2(DEPTH+1);
  localparam int          STALL_MAX  = 2000;
  localparam int          RAND_ITEMS = 1024;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              start      = 1'b0;
  logic [1:0]        kind       = KIND_PUSH_FRONT;
  logic [31:0]       push_value = '0;
  logic              busy;
  logic              done;
  logic [31:0]       pop_value;
  logic [1:0]        status;
  logic [CNT_W-1:0]  count_after;
  logic              is_empty;

  int fail_count;
  int results_seen;
  int pending;
  int full_refusals;
  int empty_refusals;
  int requests_sent = 0;
  int stall_cycles  = 0;

  always #1 clk = ~clk;

  circular_deque_unit #(.DEPTH(DEPTH)) i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .push_value  (push_value),
    .done        (done),
    .pop_value   (pop_value),
    .status      (status),
    .count_after (count_after),
    .is_empty    (is_empty)
  );

  cdq_checker #(.DEPTH(DEPTH)) i_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .kind           (kind),
    .push_value     (push_value),
    .done           (done),
    .pop_value      (pop_value),
    .status         (status),
    .count_after    (count_after),
    .is_empty       (is_empty),
    .fail_count     (fail_count),
    .results_seen   (results_seen),
    .pending        (pending),
    .full_refusals  (full_refusals),
    .empty_refusals (empty_refusals)
  );

  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("watchdog: no request or result for %0d cycles", STALL_MAX);
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [31:0] random_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 32'd1 << $urandom_range(31);
      3: return ~(32'd1 << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input kind_t k, input logic [31:0] word, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start      <= 1'b0;
      kind       <= 2'($urandom_range(3));
      push_value <= $urandom;
      @(posedge clk);
    end
    start      <= 1'b1;
    kind       <= k;
    push_value <= word;
    @(posedge clk);
    while (busy) @(posedge clk);
    requests_sent++;
  endtask

  task automatic random_phase(input int n_items, input int idle_pct);
    int    sent;
    int    burst_len;
    int    push_bias;
    kind_t k;
    sent = 0;
    while (sent < n_items) begin
      push_bias = $urandom_range(1) ? 80 : 20;
      burst_len = $urandom_range(1, 40);
      for (int i = 0; i < burst_len && sent < n_items; i++) begin
        if ($urandom_range(99) < push_bias) begin
          k = $urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
        end else begin
          k = $urandom_range(1) ? KIND_POP_FRONT : KIND_POP_BACK;
        end
        send_request(k, random_word(), idle_pct);
        sent++;
      end
    end
  endtask

  initial begin
    int idle_pct [3];
    idle_pct = '{26, 49, 0};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_request(KIND_POP_FRONT, 32'h0000_0000, 0);
    send_request(KIND_POP_BACK, 32'hFFFF_FFFF, 0);
    send_request(KIND_PUSH_FRONT, 32'hFFFF_FFFF, 0);
    send_request(KIND_POP_BACK, 32'h0000_0000, 0);
    send_request(KIND_PUSH_BACK, 32'h0000_0000, 0);
    send_request(KIND_POP_FRONT, 32'hFFFF_FFFF, 0);
    for (int i = 0; i < DEPTH; i++) begin
      send_request(i[0] ? KIND_PUSH_BACK : KIND_PUSH_FRONT,
                   i[1] ? ~(32'd1 << (2 * i)) : (32'h8000_0001 << i), 0);
    end
    send_request(KIND_PUSH_FRONT, 32'hA5A5_A5A5, 0);
    send_request(KIND_PUSH_BACK, 32'h5A5A_5A5A, 0);
    send_request(KIND_POP_FRONT, 32'h0000_0000, 0);
    send_request(KIND_POP_BACK, 32'h0000_0000, 0);

    for (int p = 0; p < 3; p++) begin
      random_phase(RAND_ITEMS / 3, idle_pct[p]);
    end
    start <= 1'b0;

    while (results_seen < requests_sent) @(posedge clk);
    repeat (8) @(posedge clk);

    if (pending != 0) $error("%0d expected results never arrived", pending);
    $display("%0d requests sent, %0d results checked", requests_sent, results_seen);
    $display("refused pushes on full ring: %0d, refused pops on empty ring: %0d",
             full_refusals, empty_refusals);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
